// ----- rtl/pts_pkg.sv -----
// Shared types and constants of the priority task scheduler.
// Used by the controller, the datapath and the top level; no dependencies.
package pts_pkg;

  localparam int unsigned TASK_SLOTS_DEF = 8;
  localparam logic [7:0] IDLE_PRIO_RESET = 8'd100;

  typedef enum logic [2:0] {
    KIND_NEW   = 3'd0,
    KIND_DELAY = 3'd1,
    KIND_TICK  = 3'd2,
    KIND_RUN   = 3'd3,
    KIND_ENTER = 3'd4,
    KIND_EXIT  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK1,
    S_APPLY,
    S_WALK2,
    S_SCHED,
    S_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic walk_start;
    logic walk_tick;
    logic apply;
    logic sched;
    logic nest_inc;
    logic nest_dec;
    logic tick_inc;
    logic set_err;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  dly_zero;
    logic  nest_zero;
    logic  nest_one;
    logic  walk_done;
    logic  free_found;
    logic  best_idle;
    logic  out_free;
  } stat_t;

endpackage

// ----- rtl/pts_ctrl.sv -----
// Control state machine of the priority task scheduler.
// Depends on pts_pkg; drives the datapath through pts_pkg::cmd_t.
module pts_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pts_pkg::stat_t stat_i,
  output pts_pkg::cmd_t  cmd_o
);

  pts_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pts_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pts_pkg::S_IDLE: begin
        if (in_valid_i) state_d = pts_pkg::S_DECODE;
      end
      pts_pkg::S_DECODE: begin
        unique case (stat_i.kind)
          pts_pkg::KIND_NEW, pts_pkg::KIND_TICK: state_d = pts_pkg::S_WALK1;
          pts_pkg::KIND_DELAY: begin
            state_d = stat_i.dly_zero ? pts_pkg::S_DONE : pts_pkg::S_WALK1;
          end
          pts_pkg::KIND_RUN: state_d = pts_pkg::S_WALK2;
          pts_pkg::KIND_EXIT: begin
            if (!stat_i.nest_zero && stat_i.nest_one) begin
              state_d = pts_pkg::S_WALK2;
            end else begin
              state_d = pts_pkg::S_DONE;
            end
          end
          default: state_d = pts_pkg::S_DONE;
        endcase
      end
      pts_pkg::S_WALK1: begin
        if (stat_i.walk_done) begin
          if (stat_i.kind == pts_pkg::KIND_TICK) begin
            state_d = pts_pkg::S_DONE;
          end else if ((stat_i.kind == pts_pkg::KIND_NEW && !stat_i.free_found) ||
                       (stat_i.kind == pts_pkg::KIND_DELAY && stat_i.best_idle)) begin
            state_d = pts_pkg::S_DONE;
          end else begin
            state_d = pts_pkg::S_APPLY;
          end
        end
      end
      pts_pkg::S_APPLY: state_d = pts_pkg::S_WALK2;
      pts_pkg::S_WALK2: begin
        if (stat_i.walk_done) state_d = pts_pkg::S_SCHED;
      end
      pts_pkg::S_SCHED: state_d = pts_pkg::S_DONE;
      pts_pkg::S_DONE: begin
        if (stat_i.out_free) state_d = pts_pkg::S_IDLE;
      end
      default: state_d = pts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      pts_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      pts_pkg::S_DECODE: begin
        unique case (stat_i.kind)
          pts_pkg::KIND_NEW, pts_pkg::KIND_RUN: cmd_o.walk_start = 1'b1;
          pts_pkg::KIND_DELAY: cmd_o.walk_start = !stat_i.dly_zero;
          pts_pkg::KIND_TICK: begin
            cmd_o.walk_start = 1'b1;
            cmd_o.walk_tick  = 1'b1;
            cmd_o.tick_inc   = 1'b1;
          end
          pts_pkg::KIND_ENTER: cmd_o.nest_inc = 1'b1;
          pts_pkg::KIND_EXIT: begin
            if (stat_i.nest_zero) begin
              cmd_o.set_err = 1'b1;
            end else begin
              cmd_o.nest_dec   = 1'b1;
              cmd_o.walk_start = stat_i.nest_one;
            end
          end
          default: cmd_o = '0;
        endcase
      end
      pts_pkg::S_WALK1: begin
        if (stat_i.walk_done &&
            ((stat_i.kind == pts_pkg::KIND_NEW && !stat_i.free_found) ||
             (stat_i.kind == pts_pkg::KIND_DELAY && stat_i.best_idle))) begin
          cmd_o.set_err = 1'b1;
        end
      end
      pts_pkg::S_APPLY: begin
        cmd_o.apply      = 1'b1;
        cmd_o.walk_start = 1'b1;
      end
      pts_pkg::S_WALK2: cmd_o = '0;
      pts_pkg::S_SCHED: cmd_o.sched = 1'b1;
      pts_pkg::S_DONE: cmd_o.load_out = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- rtl/pts_datapath.sv -----
// Datapath of the priority task scheduler: slot table, slot walker, counters
// and output register. Depends on pts_pkg; controlled through pts_pkg::cmd_t.
module pts_datapath #(
  parameter int unsigned TASK_SLOTS = pts_pkg::TASK_SLOTS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pts_pkg::cmd_t  cmd_i,
  output pts_pkg::stat_t stat_o,
  input  logic [2:0]     in_kind_i,
  input  logic [7:0]     in_prio_i,
  input  logic [15:0]    in_delay_i,
  input  logic           cfg_valid_i,
  input  logic [7:0]     cfg_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [71:0]    out_data_o
);

  localparam int unsigned SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

  pts_pkg::kind_e    kind_q;
  logic [7:0]        prio_q;
  logic [15:0]       dly_q;
  logic [7:0]        idle_prio_q;

  logic [TASK_SLOTS-1:0] used_q, ready_q;
  logic [7:0]            prio_mem [TASK_SLOTS];
  logic [15:0]           dly_mem  [TASK_SLOTS];
  logic [7:0]            prio_rd_q;
  logic [15:0]           dly_rd_q;

  logic              issue_q, tick_mode_q, rd_valid_q, done_q;
  logic [SLOT_W-1:0] cnt_q, rd_slot_q;
  logic [SLOT_W-1:0] best_q, free_q, running_q;
  logic [7:0]        best_prio_q;
  logic              free_found_q;

  logic              started_q;
  logic [7:0]        nest_q;
  logic [31:0]       switches_q, ticks_q;
  logic              sw_q, err_q;

  logic              out_valid_q;
  logic [71:0]       out_data_q;

  logic              cand, tick_wr, prio_we, dly_we;
  logic [15:0]       dly_dec, dly_wdata;
  logic [SLOT_W-1:0] dly_waddr;
  logic [SLOT_W+2:0] run_ext;

  assign cand    = used_q[rd_slot_q] && ready_q[rd_slot_q];
  assign tick_wr = rd_valid_q && tick_mode_q && used_q[rd_slot_q] && !ready_q[rd_slot_q];
  assign dly_dec = dly_rd_q - 16'd1;

  always_comb begin
    prio_we   = cmd_i.apply && (kind_q == pts_pkg::KIND_NEW);
    dly_we    = 1'b0;
    dly_waddr = rd_slot_q;
    dly_wdata = dly_dec;
    if (cmd_i.apply) begin
      dly_we = 1'b1;
      if (kind_q == pts_pkg::KIND_NEW) begin
        dly_waddr = free_q;
        dly_wdata = '0;
      end else begin
        dly_waddr = best_q;
        dly_wdata = dly_q;
      end
    end else if (tick_wr) begin
      dly_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prio_we) prio_mem[free_q] <= prio_q;
    if (dly_we) dly_mem[dly_waddr] <= dly_wdata;
    prio_rd_q <= prio_mem[cnt_q];
    dly_rd_q  <= dly_mem[cnt_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= pts_pkg::kind_e'(in_kind_i);
      prio_q <= in_prio_i;
      dly_q  <= in_delay_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_prio_q <= pts_pkg::IDLE_PRIO_RESET;
    end else if (cfg_valid_i) begin
      idle_prio_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q     <= 1'b0;
      tick_mode_q <= 1'b0;
      cnt_q       <= '0;
      rd_valid_q  <= 1'b0;
      rd_slot_q   <= '0;
      done_q      <= 1'b0;
    end else begin
      done_q     <= rd_valid_q && (rd_slot_q == LAST_SLOT);
      rd_valid_q <= issue_q;
      rd_slot_q  <= cnt_q;
      if (cmd_i.walk_start) begin
        issue_q     <= 1'b1;
        tick_mode_q <= cmd_i.walk_tick;
        cnt_q       <= SLOT_W'(1);
      end else if (issue_q) begin
        if (cnt_q == LAST_SLOT) begin
          issue_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + SLOT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_start) begin
      best_q       <= '0;
      best_prio_q  <= idle_prio_q;
      free_q       <= '0;
      free_found_q <= 1'b0;
    end else if (rd_valid_q) begin
      if (cand && (prio_rd_q < best_prio_q)) begin
        best_q      <= rd_slot_q;
        best_prio_q <= prio_rd_q;
      end
      if (!used_q[rd_slot_q] && !free_found_q) begin
        free_q       <= rd_slot_q;
        free_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= TASK_SLOTS'(1);
      ready_q <= TASK_SLOTS'(1);
    end else if (cmd_i.apply) begin
      if (kind_q == pts_pkg::KIND_NEW) begin
        used_q[free_q]  <= 1'b1;
        ready_q[free_q] <= 1'b1;
      end else begin
        ready_q[best_q] <= 1'b0;
      end
    end else if (tick_wr && (dly_dec == 16'd0)) begin
      ready_q[rd_slot_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q  <= 1'b0;
      running_q  <= '0;
      switches_q <= '0;
      ticks_q    <= '0;
      nest_q     <= '0;
      sw_q       <= 1'b0;
      err_q      <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        sw_q  <= 1'b0;
        err_q <= 1'b0;
      end
      if (cmd_i.set_err) err_q <= 1'b1;
      if (cmd_i.tick_inc) ticks_q <= ticks_q + 32'd1;
      if (cmd_i.nest_inc && (nest_q != 8'hFF)) nest_q <= nest_q + 8'd1;
      if (cmd_i.nest_dec) nest_q <= nest_q - 8'd1;
      if (cmd_i.sched) begin
        if ((kind_q == pts_pkg::KIND_RUN) && !started_q) begin
          started_q  <= 1'b1;
          running_q  <= best_q;
          switches_q <= switches_q + 32'd1;
          sw_q       <= 1'b1;
        end else if (started_q && (best_q != running_q)) begin
          running_q  <= best_q;
          switches_q <= switches_q + 32'd1;
          sw_q       <= 1'b1;
        end
      end
    end
  end

  assign run_ext = {3'b000, running_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= {3'b000, err_q, ticks_q, switches_q, run_ext[2:0], sw_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign stat_o.kind       = kind_q;
  assign stat_o.dly_zero   = (dly_q == 16'd0);
  assign stat_o.nest_zero  = (nest_q == 8'd0);
  assign stat_o.nest_one   = (nest_q == 8'd1);
  assign stat_o.walk_done  = done_q;
  assign stat_o.free_found = free_found_q;
  assign stat_o.best_idle  = (best_q == '0);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken result");

  a_idle_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q[0] && ready_q[0])
    else $error("idle slot lost its used or ready mark");

  a_apply_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply |-> (!issue_q && !rd_valid_q))
    else $error("slot table updated during a walk");

  a_switch_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(switches_q) |-> $past(cmd_i.sched))
    else $error("switch count moved outside scheduling");
`endif

endmodule

// ----- rtl/priority_task_scheduler_with_delays.sv -----
// Top level of the priority task scheduler with tick delays.
// Depends on pts_pkg, pts_ctrl and pts_datapath.
//
// Each request on the input stream is one kernel event (new task, delay,
// tick, run, ISR enter, ISR exit), and each produces exactly one result on
// the output stream. Task state lives in a table of TASK_SLOTS slots; the
// priority and delay fields sit in memories that a walker reads one slot per
// cycle. Enter, an exit that stays inside a nested ISR, an ISR underflow, a
// zero delay and the unused kinds do not walk the table; a tick, and a new
// task or a delay that is refused after its first walk, walk it once; a run
// and an exit of the outermost ISR walk it once and then schedule; a new
// task and a delay that are carried out walk twice (find, then schedule).
// A stalled result holds the next request back only at its last step, the
// loading of its result. The idle priority register may be written only
// while no event is in progress and takes effect at once.
module priority_task_scheduler_with_delays #(
  parameter int unsigned TASK_SLOTS = pts_pkg::TASK_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: task_priority [7:0], delay_ticks [23:8]
  input  logic [23:0] s_axis_tdata_i,
  // tuser: kind [2:0]
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: switched [0], running_slot [3:1], switch_count [35:4],
  // tick_count [67:36], error [68], zero fill [71:69]
  output logic [71:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  pts_pkg::cmd_t  cmd;
  pts_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  pts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pts_datapath #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_kind_i   (s_axis_tuser_i),
    .in_prio_i   (s_axis_tdata_i[7:0]),
    .in_delay_i  (s_axis_tdata_i[23:8]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule
